// File: src/tftm_pkg.sv
`timescale 1ns / 1ps
// tftm_pkg: shared constants, types and the per-entry matcher step function
// for the topic filter table matcher; depends on nothing

package tftm_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int FILTER_MAX  = 64;
  localparam int ADDR_W      = $clog2(FILTER_MAX);

  // fixed field widths
  localparam int FUNC_W  = 2;
  localparam int ENTRY_W = 3;
  localparam int POS_W   = 6;
  localparam int CHAR_W  = 8;

  // filter store bytes read per entry and per cycle: positions f, f+1, f+2
  localparam int RD_TAPS = 3;

  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE_CHAR = 2'd0,
    FUNC_SET_ENTRY  = 2'd1,
    FUNC_TOPIC_CHAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_MATCH = 2'd1,
    ST_FAIL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]   position;
    logic [CHAR_W-1:0]  filter_char;
    logic [POS_W-1:0]   filter_length;
    logic               active;
    logic [CHAR_W-1:0]  topic_char;
    logic               last;
  } in_word_t;

  // control from the top level to one entry
  typedef struct packed {
    logic fire;
    logic sel;
  } ent_ctl_t;

  // filter symbol: a byte or end of filter
  typedef struct packed {
    logic              is_end;
    logic [CHAR_W-1:0] ch;
  } sym_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             als;
    logic             ipl;
    status_t          status;
  } match_st_t;

  localparam match_st_t MATCH_RESTART = '{pos: '0, als: 1'b1, ipl: 1'b0, status: ST_RUN};

  // one matcher step on topic symbol x (byte, or end when x_end)
  // c0, c1 are the filter symbols at the current position and the one after
  function automatic match_st_t advance(input match_st_t s, input logic x_end,
                                        input logic [CHAR_W-1:0] x,
                                        input sym_t c0, input sym_t c1);
    match_st_t n;
    logic      x_slash;
    logic      c0_slash;
    logic      c0_hash;
    logic      c0_plus;
    logic      c1_hash;
    n        = s;
    x_slash  = !x_end && (x == CH_SLASH);
    c0_slash = !c0.is_end && (c0.ch == CH_SLASH);
    c0_hash  = !c0.is_end && (c0.ch == CH_HASH);
    c0_plus  = !c0.is_end && (c0.ch == CH_PLUS);
    c1_hash  = !c1.is_end && (c1.ch == CH_HASH);
    // inside a plus level every byte but a separator is swallowed
    if (s.status == ST_RUN && !(s.ipl && !x_end && !x_slash)) begin
      n.ipl = 1'b0;
      if (!s.als && c0_slash) begin
        if (x_end && c1_hash) begin
          n.status = ST_MATCH;
        end else if (!x_slash) begin
          n.status = ST_FAIL;
        end else begin
          n.pos = s.pos + 1'b1;
          n.als = 1'b1;
        end
      end else if (!s.als && x_slash) begin
        n.status = ST_FAIL;
      end else if (c0.is_end) begin
        n.status = x_end ? ST_MATCH : ST_FAIL;
      end else if (s.als && c0_hash) begin
        n.status = ST_MATCH;
      end else if (s.als && c0_plus) begin
        if (x_end || x_slash) begin
          n.status = ST_FAIL;
        end else begin
          n.ipl = 1'b1;
          n.pos = s.pos + 1'b1;
          n.als = 1'b0;
        end
      end else if (x_end || (c0.ch != x)) begin
        n.status = ST_FAIL;
      end else begin
        n.pos = s.pos + 1'b1;
        n.als = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

// File: src/tftm_if.sv
`timescale 1ns / 1ps
// tftm_in_if and tftm_out_if: valid/ready channels of the topic filter matcher
// depends on nothing

interface tftm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] entry;
  logic [5:0] position;
  logic [7:0] filter_char;
  logic [5:0] filter_length;
  logic       active;
  logic [7:0] topic_char;
  logic       last;

  modport source (
    output valid, func, entry, position, filter_char, filter_length, active, topic_char,
           last,
    input  ready
  );
  modport sink (
    input  valid, func, entry, position, filter_char, filter_length, active, topic_char,
           last,
    output ready
  );
endinterface

interface tftm_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] hit_entry;

  modport source (output valid, hit, hit_entry, input ready);
  modport sink (input valid, hit, hit_entry, output ready);
endinterface

// File: src/tftm_ram.sv
`timescale 1ns / 1ps
// tftm_ram: generic one-write one-read memory with registered read data
// depends on nothing

module tftm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/tftm_entry.sv
`timescale 1ns / 1ps
// tftm_entry: one filter table entry with its store, length, flag and matcher
// depends on tftm_pkg and tftm_ram

module tftm_entry (
  input  logic               clk,
  input  logic               rst_n,
  input  tftm_pkg::ent_ctl_t ctl,
  input  tftm_pkg::in_word_t word,
  output logic               matched
);

  tftm_pkg::match_st_t st_r, st_nxt;
  tftm_pkg::match_st_t st_byte, st_end;
  logic [tftm_pkg::POS_W-1:0] len_r, len_nxt;
  logic                       act_r, act_nxt;

  logic                                 wr_en;
  logic [tftm_pkg::ADDR_W-1:0]          wr_addr;
  logic [tftm_pkg::ADDR_W-1:0]          rd_addr [tftm_pkg::RD_TAPS];
  logic [tftm_pkg::CHAR_W-1:0]          ram_q   [tftm_pkg::RD_TAPS];
  logic [tftm_pkg::RD_TAPS-1:0]         byp_r, byp_nxt;
  logic [tftm_pkg::CHAR_W-1:0]          byp_data_r;
  tftm_pkg::sym_t                       sym     [tftm_pkg::RD_TAPS];
  tftm_pkg::sym_t                       e0, e1;
  logic                                 is_topic;

  assign is_topic = ctl.fire && (word.func == tftm_pkg::FUNC_TOPIC_CHAR);
  assign wr_en    = ctl.fire && ctl.sel && (word.func == tftm_pkg::FUNC_WRITE_CHAR) &&
                    (int'(word.position) < tftm_pkg::FILTER_MAX);
  assign wr_addr  = tftm_pkg::ADDR_W'(word.position);

  // three copies of the store so that f, f+1 and f+2 are read every cycle
  for (genvar k = 0; k < tftm_pkg::RD_TAPS; k++) begin : g_tap
    logic [tftm_pkg::POS_W:0] q_rd;
    logic [tftm_pkg::POS_W:0] q_cur;

    assign q_rd       = {1'b0, st_nxt.pos} + (tftm_pkg::POS_W+1)'(k);
    assign q_cur      = {1'b0, st_r.pos} + (tftm_pkg::POS_W+1)'(k);
    assign rd_addr[k] = tftm_pkg::ADDR_W'(q_rd);
    assign byp_nxt[k] = wr_en && (wr_addr == rd_addr[k]);

    tftm_ram #(
      .WIDTH (tftm_pkg::CHAR_W),
      .DEPTH (tftm_pkg::FILTER_MAX)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (word.filter_char),
      .raddr (rd_addr[k]),
      .rdata (ram_q[k])
    );

    // positions at or past the clipped length read as end
    assign sym[k].is_end = (q_cur >= {1'b0, len_r}) ||
                           (int'(q_cur) >= tftm_pkg::FILTER_MAX);
    assign sym[k].ch     = byp_r[k] ? byp_data_r : ram_q[k];
  end

  // write in the same cycle as the read: forward the new byte
  always_ff @(posedge clk) begin
    byp_r      <= byp_nxt;
    byp_data_r <= word.filter_char;
  end

  always_comb begin
    st_byte = tftm_pkg::advance(st_r, 1'b0, word.topic_char, sym[0], sym[1]);
    if (st_byte.pos != st_r.pos) begin
      e0 = sym[1];
      e1 = sym[2];
    end else begin
      e0 = sym[0];
      e1 = sym[1];
    end
    st_end  = tftm_pkg::advance(st_byte, 1'b1, '0, e0, e1);
    matched = (st_end.status == tftm_pkg::ST_MATCH) && (len_r != '0) && act_r;
  end

  always_comb begin
    st_nxt  = st_r;
    len_nxt = len_r;
    act_nxt = act_r;
    if (is_topic) begin
      st_nxt = word.last ? tftm_pkg::MATCH_RESTART : st_byte;
    end
    if (ctl.fire && ctl.sel && (word.func == tftm_pkg::FUNC_SET_ENTRY)) begin
      len_nxt = word.filter_length;
      act_nxt = word.active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= tftm_pkg::MATCH_RESTART;
      len_r <= '0;
      act_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
      act_r <= act_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_plus_not_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ipl |-> !st_r.als)
    else $error("plus level open at a level start");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    is_topic && word.last |=> st_r.pos == '0 && st_r.als && !st_r.ipl &&
                              st_r.status == tftm_pkg::ST_RUN)
    else $error("matcher not restarted after last topic byte");

  a_len_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.fire |=> $stable(len_r) && $stable(act_r) && $stable(st_r))
    else $error("entry state changed without an item");
`endif

endmodule

// File: src/topic_filter_table_match.sv
`timescale 1ns / 1ps
// topic_filter_table_match: top level, input stage, entry array, result register
// depends on tftm_pkg, tftm_if and tftm_entry
//
// channel  dir  handshake           word
// in_ch    in   valid/ready         func, entry, position, filter_char,
//                                   filter_length, active, topic_char, last
// out_ch   out  valid/ready         hit, hit_entry
//
// one word per cycle while the stage does not stall; a result passes through the stage register,
// then the result register, and is computed by the entry matchers running in parallel
// each entry's filter store is three copies of a registered-read memory, read at f..f+2
// reset clears lengths, active flags and matcher state; the filter store is not cleared
// the stage stalls only when it holds a last topic byte, the result register is full and out_ch is not ready

module topic_filter_table_match (
  input  logic              clk,
  input  logic              rst_n,
  tftm_in_if.sink           in_ch,
  tftm_out_if.source        out_ch
);

  // input stage
  logic               s_valid_r, s_valid_nxt;
  tftm_pkg::in_word_t s_word_r, s_word_nxt;
  tftm_pkg::in_word_t in_word;
  logic               s_result;   // stage word produces a result
  logic               s_fire;     // stage word is processed this cycle
  logic               in_take;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic [tftm_pkg::ENTRY_W-1:0] out_entry_r, out_entry_nxt;

  // entry array
  tftm_pkg::ent_ctl_t                 ent_ctl [tftm_pkg::NUM_ENTRIES];
  logic [tftm_pkg::NUM_ENTRIES-1:0]   ent_match;
  logic                               res_hit;
  logic [tftm_pkg::ENTRY_W-1:0]       res_entry;

  assign in_word = '{
    func:          in_ch.func,
    entry:         in_ch.entry,
    position:      in_ch.position,
    filter_char:   in_ch.filter_char,
    filter_length: in_ch.filter_length,
    active:        in_ch.active,
    topic_char:    in_ch.topic_char,
    last:          in_ch.last
  };

  // only a last topic byte needs room in the result register
  assign s_result    = (s_word_r.func == tftm_pkg::FUNC_TOPIC_CHAR) && s_word_r.last;
  assign s_fire      = s_valid_r && (!s_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s_valid_r || s_fire;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    s_word_nxt  = s_word_r;
    if (in_take) begin
      s_valid_nxt = 1'b1;
      s_word_nxt  = in_word;
    end else if (s_fire) begin
      s_valid_nxt = 1'b0;
    end
  end

  // every entry steps on the same word
  for (genvar e = 0; e < tftm_pkg::NUM_ENTRIES; e++) begin : g_ent
    assign ent_ctl[e] = '{fire: s_fire, sel: (int'(s_word_r.entry) == e)};

    tftm_entry u_entry (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ent_ctl[e]),
      .word    (s_word_r),
      .matched (ent_match[e])
    );
  end

  // lowest matching entry wins
  always_comb begin
    res_hit   = |ent_match;
    res_entry = '0;
    for (int e = tftm_pkg::NUM_ENTRIES - 1; e >= 0; e--) begin
      if (ent_match[e]) begin
        res_entry = tftm_pkg::ENTRY_W'(e);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_entry_nxt = out_entry_r;
    if (s_fire && s_result) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = res_hit;
      out_entry_nxt = res_entry;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s_word_r    <= s_word_nxt;
    out_hit_r   <= out_hit_nxt;
    out_entry_r <= out_entry_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.hit_entry = out_entry_r;

`ifndef NO_ASSERTIONS
  a_no_hit_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_entry_r == '0)
    else $error("hit_entry nonzero without a hit");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && !s_fire |=> s_valid_r && $stable(s_word_r))
    else $error("stalled stage word lost or changed");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s_fire && s_result |=> out_valid_r && out_hit_r == $past(res_hit))
    else $error("result of a last topic byte not loaded");
`endif

endmodule

// File: test/tb_topic_filter_table_match.sv
`timescale 1ns / 1ps
// tb_topic_filter_table_match: self-checking bench for the topic filter table matcher
// depends on tftm_pkg, tftm_if and the topic_filter_table_match top level

import tftm_pkg::*;

typedef logic [7:0] text_t[$];

typedef struct packed {
  logic       hit;
  logic [2:0] hit_entry;
} hit_report_t;

// mirror of the filter table and of every entry's matcher, plus the hits still owed
class filter_matcher;
  localparam int FILTER_END = 256;

  bit [7:0]      filt [NUM_ENTRIES][FILTER_MAX];
  int            flen [NUM_ENTRIES];
  bit            subscribed [NUM_ENTRIES];
  int            fpos [NUM_ENTRIES];
  bit            lvl_start [NUM_ENTRIES];
  bit            plus_lvl [NUM_ENTRIES];
  status_t       state [NUM_ENTRIES];
  hit_report_t   pending_hits[$];
  int            errors;

  function new();
    errors = 0;
    foreach (flen[e]) begin
      flen[e]       = 0;
      subscribed[e] = 0;
    end
    restart();
  endfunction

  function void restart();
    foreach (fpos[e]) begin
      fpos[e]      = 0;
      lvl_start[e] = 1;
      plus_lvl[e]  = 0;
      state[e]     = ST_RUN;
    end
  endfunction

  // filter byte at p, or end past the entry's length
  function int filter_sym(int e, int p);
    if (p >= flen[e]) return FILTER_END;
    return filt[e][p];
  endfunction

  // one matcher step of entry e on topic byte x, or on end of topic
  function void advance_entry(int e, int x);
    int f;
    int c;
    bit at_end;
    f      = fpos[e];
    at_end = (x == FILTER_END);
    if (state[e] != ST_RUN) return;
    if (plus_lvl[e]) begin
      if (!at_end && x != CH_SLASH) return;
      plus_lvl[e] = 0;
    end
    if (!lvl_start[e]) begin
      // after a consumed element only a separator or the end may follow
      if (filter_sym(e, f) == CH_SLASH) begin
        if (at_end && filter_sym(e, f + 1) == CH_HASH) begin
          state[e] = ST_MATCH;
          return;
        end
        if (at_end || x != CH_SLASH) begin
          state[e] = ST_FAIL;
          return;
        end
        fpos[e]      = f + 1;
        lvl_start[e] = 1;
        return;
      end
      if (!at_end && x == CH_SLASH) begin
        state[e] = ST_FAIL;
        return;
      end
    end
    c = filter_sym(e, f);
    if (c == FILTER_END) begin
      state[e] = at_end ? ST_MATCH : ST_FAIL;
      return;
    end
    if (lvl_start[e] && c == CH_HASH) begin
      state[e] = ST_MATCH;
      return;
    end
    if (lvl_start[e] && c == CH_PLUS) begin
      if (at_end || x == CH_SLASH) begin
        state[e] = ST_FAIL;
        return;
      end
      plus_lvl[e] = 1;
    end else if (at_end || c != x) begin
      state[e] = ST_FAIL;
      return;
    end
    fpos[e]      = f + 1;
    lvl_start[e] = 0;
  endfunction

  function void take_word(in_word_t w);
    hit_report_t r;
    case (w.func)
      FUNC_WRITE_CHAR: filt[w.entry][w.position] = w.filter_char;
      FUNC_SET_ENTRY: begin
        flen[w.entry]       = w.filter_length;
        subscribed[w.entry] = w.active;
      end
      FUNC_TOPIC_CHAR: begin
        for (int e = 0; e < NUM_ENTRIES; e++) advance_entry(e, w.topic_char);
        if (w.last) begin
          for (int e = 0; e < NUM_ENTRIES; e++) advance_entry(e, FILTER_END);
          r = '0;
          for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (flen[e] != 0 && subscribed[e] && state[e] == ST_MATCH) begin
              r.hit       = 1'b1;
              r.hit_entry = 3'(e);
              break;
            end
          end
          pending_hits.push_back(r);
          restart();
        end
      end
      default: ;
    endcase
  endfunction

  function void check_hit(logic hit, logic [2:0] hit_entry);
    hit_report_t want;
    if (pending_hits.size() == 0) begin
      $error("unexpected result: hit %0d hit_entry %0d", hit, hit_entry);
      errors++;
      return;
    end
    want = pending_hits.pop_front();
    if (hit !== want.hit) begin
      $error("hit: expected %0d, actual %0d", want.hit, hit);
      errors++;
    end
    if (hit_entry !== want.hit_entry) begin
      $error("hit_entry: expected %0d, actual %0d", want.hit_entry, hit_entry);
      errors++;
    end
  endfunction

  function int pending();
    return pending_hits.size();
  endfunction
endclass

module tb_topic_filter_table_match;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;  // not decoded by the block
  localparam int IDLE_LIMIT   = 2000;          // cycles with no word moving on either side
  localparam int LONG_HOLD    = 100;           // receiver back-pressure stretch
  localparam int RANDOM_WORDS = 1500;

  logic clk;
  logic rst_n;

  tftm_in_if  in_ch ();
  tftm_out_if out_ch ();

  topic_filter_table_match dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  filter_matcher table_model;

  // filter positions ever written; a length may only cover written bytes
  bit written [NUM_ENTRIES][FILTER_MAX];
  bit no_idle;        // both sides run without gaps while set
  bit hold_request;   // asks the receiver for one long stall
  bit mix_noise;      // sprinkle table writes and dead words into topics
  int words_sent;
  int idle_cycles;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: trips when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // fields that the func does not use carry random bits
  function automatic in_word_t random_word();
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic text_t to_text(string s);
    text_t t;
    foreach (s[i]) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] pick_lit();
    case ($urandom_range(0, 2))
      0:       return "a";
      1:       return "b";
      default: return "c";
    endcase
  endfunction

  // literal or one of the three special bytes
  function automatic logic [7:0] pick_any();
    case ($urandom_range(0, 5))
      0:       return CH_SLASH;
      1:       return CH_PLUS;
      2:       return CH_HASH;
      default: return pick_lit();
    endcase
  endfunction

  function automatic int written_prefix(int e);
    int n;
    n = 0;
    while (n < FILTER_MAX && written[e][n]) n++;
    return n;
  endfunction

  // random filter of one to four levels: plus, hash, empty or short literal,
  // sometimes with a wildcard byte trailing a literal
  function automatic text_t make_filter();
    text_t f;
    int    k;
    for (int l = 0; l < $urandom_range(1, 4); l++) begin
      if (l != 0) f.push_back(CH_SLASH);
      k = $urandom_range(0, 19);
      if (k < 4) begin
        f.push_back(CH_PLUS);
      end else if (k < 7) begin
        f.push_back(CH_HASH);
      end else if (k > 7) begin
        repeat ($urandom_range(1, 3)) f.push_back(pick_lit());
        if (k == 19) f.push_back($urandom_range(0, 1) ? CH_PLUS : CH_HASH);
      end
    end
    return f;
  endfunction

  // mostly topics built from a loaded filter so that matchers get deep,
  // the rest loose strings over the special bytes or raw bytes
  function automatic text_t make_topic();
    text_t      t;
    int         e;
    int         kind;
    int         n;
    logic [7:0] c;
    bit         start;
    kind = $urandom_range(0, 99);
    e    = $urandom_range(0, NUM_ENTRIES - 1);
    if (kind < 60 && table_model.flen[e] != 0) begin
      for (int p = 0; p < table_model.flen[e]; p++) begin
        c     = table_model.filt[e][p];
        start = (p == 0) ? 1'b1 : (table_model.filt[e][p-1] == CH_SLASH);
        if (start && c == CH_PLUS) begin
          // one level, now and then an empty one
          if ($urandom_range(0, 9) != 0) repeat ($urandom_range(1, 3)) t.push_back(pick_lit());
        end else if (start && c == CH_HASH) begin
          // zero levels, with or without the separator, or a few levels
          if ($urandom_range(0, 1) && t.size() != 0 && t[$] == CH_SLASH) begin
            void'(t.pop_back());
          end else begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++) begin
              if (i != 0) t.push_back(CH_SLASH);
              repeat ($urandom_range(1, 2)) t.push_back(pick_lit());
            end
          end
          break;
        end else begin
          t.push_back(c);
        end
      end
      if ($urandom_range(0, 6) == 0 && t.size() != 0)
        t[$urandom_range(0, t.size() - 1)] = pick_any();
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) t.push_back(pick_any());
    end else begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom));
    end
    if (t.size() == 0) t.push_back(pick_lit());
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks: inputs change at the falling edge, handshake seen at the rising
  // ---------------------------------------------------------------------------

  task automatic put_word(in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func          = w.func;
    in_ch.entry         = w.entry;
    in_ch.position      = w.position;
    in_ch.filter_char   = w.filter_char;
    in_ch.filter_length = w.filter_length;
    in_ch.active        = w.active;
    in_ch.topic_char    = w.topic_char;
    in_ch.last          = w.last;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    table_model.take_word(w);
    if (w.func != FUNC_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  task automatic put_char(int e, int p, logic [7:0] c);
    in_word_t w;
    w             = random_word();
    w.func        = FUNC_WRITE_CHAR;
    w.entry       = 3'(e);
    w.position    = 6'(p);
    w.filter_char = c;
    put_word(w);
    written[e][p] = 1'b1;
  endtask

  task automatic put_entry(int e, int len, bit act);
    in_word_t w;
    w               = random_word();
    w.func          = FUNC_SET_ENTRY;
    w.entry         = 3'(e);
    w.filter_length = 6'(len);
    w.active        = act;
    put_word(w);
  endtask

  task automatic put_dead_word();
    in_word_t w;
    w      = random_word();
    w.func = FUNC_UNUSED;
    put_word(w);
  endtask

  task automatic load_filter(int e, text_t f, bit act);
    foreach (f[p]) put_char(e, p, f[p]);
    put_entry(e, f.size(), act);
  endtask

  // one topic, last flag on its final byte; table writes mid-topic act at once
  task automatic put_topic(text_t t);
    in_word_t w;
    foreach (t[i]) begin
      if (mix_noise && $urandom_range(0, 24) == 0)
        put_char($urandom_range(0, NUM_ENTRIES - 1), $urandom_range(0, FILTER_MAX - 1),
                 pick_any());
      if (mix_noise && $urandom_range(0, 49) == 0) put_dead_word();
      w            = random_word();
      w.func       = FUNC_TOPIC_CHAR;
      w.topic_char = t[i];
      w.last       = (i == t.size() - 1);
      put_word(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold on request
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    bit hold_done;
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      table_model.check_hit(out_ch.hit, out_ch.hit_entry);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    text_t t;
    int    e;
    int    n;
    int    pick;
    int    burst_mark;
    bit    held;
    bit    paused;
    bit    saved;

    table_model         = new();
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = '0;
    in_ch.entry         = '0;
    in_ch.position      = '0;
    in_ch.filter_char   = '0;
    in_ch.filter_length = '0;
    in_ch.active        = 1'b0;
    in_ch.topic_char    = '0;
    in_ch.last          = 1'b0;
    no_idle             = 1'b0;
    hold_request        = 1'b0;
    mix_noise           = 1'b0;
    words_sent          = 0;
    held                = 1'b0;
    paused              = 1'b0;
    burst_mark          = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: trailing hash, plus level, literal hash after a literal
    load_filter(2, to_text("a/#"), 1'b1);
    load_filter(5, to_text("+/b"), 1'b1);
    load_filter(1, to_text("a#"), 1'b1);
    put_topic(to_text("a"));      // hash takes zero levels
    put_topic(to_text("a#"));     // hash not at level start is literal
    put_topic(to_text("x/b"));    // plus swallows one level
    put_topic(to_text("/b"));     // plus refuses an empty level
    begin
      in_word_t w;
      w      = random_word();
      w.func = FUNC_UNUSED;
      w.last = 1'b1;              // unused func with last set gives no result
      put_word(w);
    end
    put_entry(2, 3, 1'b0);        // unsubscribed entry never reports
    put_topic(to_text("a"));
    put_entry(1, 0, 1'b1);        // empty slot never reports even when active
    put_topic(to_text("a#"));

    // random part
    mix_noise = 1'b1;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent >= burst_mark) begin
        burst_mark += 150;
        no_idle = ($urandom_range(0, 3) == 0);
      end
      // receiver stalls long while single-byte topics keep coming: the block fills up
      if (!held && words_sent >= 500) begin
        held         = 1'b1;
        hold_request = 1'b1;
        saved        = no_idle;
        no_idle      = 1'b1;
        repeat (16) put_topic(to_text("a"));
        no_idle      = saved;
      end
      // sender pause until every owed result is back
      if (!paused && words_sent >= 1000) begin
        paused      = 1'b1;
        in_ch.valid = 1'b0;
        while (table_model.pending() != 0) @(negedge clk);
      end
      e    = $urandom_range(0, NUM_ENTRIES - 1);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        load_filter(e, make_filter(), $urandom_range(0, 4) != 0);
      end else if (pick == 8) begin
        // longest filter the length field allows
        t = {};
        repeat (FILTER_MAX - 1) t.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : pick_any());
        load_filter(e, t, $urandom_range(0, 1));
      end else if (pick < 13) begin
        n = written_prefix(e);
        if (n > FILTER_MAX - 1) n = FILTER_MAX - 1;
        put_entry(e, $urandom_range(0, n), $urandom_range(0, 1));
      end else if (pick < 16) begin
        put_char(e, $urandom_range(0, FILTER_MAX - 1), 8'($urandom));
      end else if (pick == 16) begin
        put_dead_word();
      end else begin
        put_topic(make_topic());
      end
    end

    // drain, then allow the two-stage latency to show any stray result
    in_ch.valid = 1'b0;
    while (table_model.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (table_model.errors == 0 && table_model.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
